// ===== rtl/crtc_pkg.sv =====
// Shared types and constants for the CRT controller command interface.
package crtc_pkg;

   typedef enum logic [2:0] {
      OP_PARAM_WRITE   = 3'd0,
      OP_COMMAND_WRITE = 3'd1,
      OP_STATUS_READ   = 3'd2,
      OP_PARAM_READ    = 3'd3,
      OP_FRAME_POLL    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CMD_RESET             = 3'd0,
      CMD_START_DISPLAY     = 3'd1,
      CMD_STOP_DISPLAY      = 3'd2,
      CMD_READ_LIGHT_PEN    = 3'd3,
      CMD_LOAD_CURSOR       = 3'd4,
      CMD_ENABLE_INTERRUPT  = 3'd5,
      CMD_DISABLE_INTERRUPT = 3'd6,
      CMD_PRESET            = 3'd7
   } cmd_type;

   localparam int PARAM_DEPTH = 5;

   typedef logic [7:0] param_array_type [PARAM_DEPTH];

   // status byte bits
   localparam logic [6:0] ST_FIFO_OVERRUN  = 7'h01;
   localparam logic [6:0] ST_DMA_UNDERRUN  = 7'h02;
   localparam logic [6:0] ST_VIDEO_ENABLE  = 7'h04;
   localparam logic [6:0] ST_IMPROPER_CMD  = 7'h08;
   localparam logic [6:0] ST_LIGHT_PEN     = 7'h10;
   localparam logic [6:0] ST_INT_REQUEST   = 7'h20;
   localparam logic [6:0] ST_INT_ENABLE    = 7'h40;

   // bytes collected before a command runs, command byte included
   function automatic logic [2:0] cmd_length(cmd_type cmd);
      logic [2:0] len;
      unique case (cmd)
         CMD_RESET:             len = 3'd5;
         CMD_START_DISPLAY:     len = 3'd1;
         CMD_STOP_DISPLAY:      len = 3'd1;
         CMD_READ_LIGHT_PEN:    len = 3'd3;
         CMD_LOAD_CURSOR:       len = 3'd3;
         CMD_ENABLE_INTERRUPT:  len = 3'd1;
         CMD_DISABLE_INTERRUPT: len = 3'd1;
         CMD_PRESET:            len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/crtc_if.sv =====
// Request and response channel interfaces of the CRT controller command interface.
interface crtc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [7:0]  data;
   logic [13:0] dma_count;
   logic        cpu_int_enabled;
   logic        frame_changed;

   modport source (output valid, op, data, dma_count, cpu_int_enabled, frame_changed,
                   input ready);
   modport sink (input valid, op, data, dma_count, cpu_int_enabled, frame_changed,
                 output ready);
endinterface

interface crtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       interrupt_pulse;
   logic       screen_update;
   logic       clear_screen;
   logic [7:0] columns;
   logic [6:0] rows_out;
   logic [4:0] underline_line;
   logic [1:0] cursor_format;
   logic [7:0] cursor_col;
   logic [7:0] cursor_row;

   modport source (output valid, read_data, interrupt_pulse, screen_update, clear_screen,
                   columns, rows_out, underline_line, cursor_format, cursor_col,
                   cursor_row,
                   input ready);
   modport sink (input valid, read_data, interrupt_pulse, screen_update, clear_screen,
                 columns, rows_out, underline_line, cursor_format, cursor_col, cursor_row,
                 output ready);
endinterface

// ===== rtl/crt_controller_command_interface_unit.sv =====
// CRT controller command interface: bus register model with one response per request.
//
// Each request on req_chan is a bus access or a frame poll: parameter write,
// command write, status read, parameter read or poll. Every request gives
// exactly one response on rsp_chan carrying the status byte (status reads),
// the interrupt, redraw and clear-screen pulses, and the programmed geometry
// and cursor as they stand after the request.
// The response is registered: a request accepted at one edge has its response
// valid after that edge. Throughput is one request per cycle while the
// receiver keeps taking responses; all decode, command execution and the
// screen-size multiply sit between the state registers and the response register.
// req_chan.ready is high while the response register is empty or being
// taken, so a stalled receiver holds the response and back-pressures the
// request side without losing or repeating anything.
// Reset clears the status, the parameter buffer, geometry, cursor and the
// buffer-ready mark, and empties the response register.
module crt_controller_command_interface_unit (
   input logic         clock,
   input logic         reset,
   crtc_req_if.sink    req_chan,
   crtc_rsp_if.source  rsp_chan
);
   import crtc_pkg::*;

   logic            accept;
   param_array_type param_bytes_ff, param_bytes_in;
   logic [2:0]      param_count_ff, param_count_in;
   logic [6:0]      status_ff, status_in;
   logic [7:0]      col_count_ff, col_count_in;
   logic [6:0]      row_count_ff, row_count_in;
   logic [4:0]      underline_ff, underline_in;
   logic [1:0]      cursor_style_ff, cursor_style_in;
   logic [7:0]      cursor_x_ff, cursor_x_in;
   logic [7:0]      cursor_y_ff, cursor_y_in;
   logic            cursor_dirty_ff, cursor_dirty_in;
   logic            buffer_ready_ff, buffer_ready_in;

   logic            rsp_valid_ff;
   logic [7:0]      read_data_ff, read_data_in;
   logic            int_pulse_ff, int_pulse_in;
   logic            update_ff, update_in;
   logic            clear_ff, clear_in;

   logic            check;
   cmd_type         cmd;
   logic [14:0]     screen_size;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign screen_size = 15'(col_count_ff) * 15'(row_count_ff);

   always_comb begin
      param_bytes_in  = param_bytes_ff;
      param_count_in  = param_count_ff;
      status_in       = status_ff;
      col_count_in    = col_count_ff;
      row_count_in    = row_count_ff;
      underline_in    = underline_ff;
      cursor_style_in = cursor_style_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      cursor_dirty_in = cursor_dirty_ff;
      buffer_ready_in = buffer_ready_ff;
      read_data_in    = 8'd0;
      int_pulse_in    = 1'b0;
      update_in       = 1'b0;
      clear_in        = 1'b0;
      check           = 1'b0;

      unique case (req_chan.op)
         OP_PARAM_WRITE: begin
            if (param_count_ff >= 3'(PARAM_DEPTH)) begin
               // index past the buffer: drop the byte and restart
               param_count_in = 3'd0;
            end else begin
               param_bytes_in[param_count_ff] = req_chan.data;
               param_count_in = param_count_ff + 3'd1;
               check = 1'b1;
            end
         end
         OP_COMMAND_WRITE: begin
            param_bytes_in[0] = req_chan.data;
            param_count_in = 3'd1;
            check = 1'b1;
         end
         OP_STATUS_READ: begin
            read_data_in = {1'b0, status_ff};
            status_in = status_ff & (ST_VIDEO_ENABLE | ST_INT_ENABLE);
         end
         OP_FRAME_POLL: begin
            if (req_chan.cpu_int_enabled && ((status_ff & ST_VIDEO_ENABLE) != 7'd0)
                && buffer_ready_ff) begin
               if ({1'b0, req_chan.dma_count} < screen_size) begin
                  status_in = status_ff | ST_DMA_UNDERRUN;
               end else begin
                  if (cursor_dirty_ff || req_chan.frame_changed) begin
                     cursor_dirty_in = 1'b0;
                     update_in = 1'b1;
                  end
                  if ((status_ff & ST_INT_ENABLE) != 7'd0) begin
                     status_in = status_ff | ST_INT_REQUEST;
                     int_pulse_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      cmd = cmd_type'(param_bytes_in[0][7:5]);

      if (check && (param_count_in == cmd_length(cmd))) begin
         param_count_in = 3'd0;
         unique case (cmd) inside
            CMD_RESET: begin
               status_in       = 7'd0;
               col_count_in    = {1'b0, param_bytes_in[1][6:0]} + 8'd1;
               row_count_in    = {1'b0, param_bytes_in[2][5:0]} + 7'd1;
               underline_in    = {1'b0, param_bytes_in[3][7:4]} + 5'd1;
               cursor_style_in = param_bytes_in[4][5:4];
               buffer_ready_in = 1'b1;
            end
            CMD_START_DISPLAY: begin
               status_in    = status_in | ST_INT_ENABLE | ST_VIDEO_ENABLE;
               clear_in     = 1'b1;
               int_pulse_in = 1'b1;
            end
            CMD_STOP_DISPLAY: status_in = status_in & ~ST_VIDEO_ENABLE;
            CMD_LOAD_CURSOR: begin
               cursor_x_in     = param_bytes_in[1];
               cursor_y_in     = param_bytes_in[2];
               cursor_dirty_in = 1'b1;
            end
            CMD_ENABLE_INTERRUPT:  status_in = status_in | ST_INT_ENABLE;
            CMD_DISABLE_INTERRUPT: status_in = status_in & ~ST_INT_ENABLE;
            CMD_READ_LIGHT_PEN, CMD_PRESET: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARAM_DEPTH; i++) param_bytes_ff[i] <= 8'd0;
         param_count_ff  <= 3'd0;
         status_ff       <= 7'd0;
         col_count_ff    <= 8'd0;
         row_count_ff    <= 7'd0;
         underline_ff    <= 5'd0;
         cursor_style_ff <= 2'd0;
         cursor_x_ff     <= 8'd0;
         cursor_y_ff     <= 8'd0;
         cursor_dirty_ff <= 1'b0;
         buffer_ready_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            param_bytes_ff  <= param_bytes_in;
            param_count_ff  <= param_count_in;
            status_ff       <= status_in;
            col_count_ff    <= col_count_in;
            row_count_ff    <= row_count_in;
            underline_ff    <= underline_in;
            cursor_style_ff <= cursor_style_in;
            cursor_x_ff     <= cursor_x_in;
            cursor_y_ff     <= cursor_y_in;
            cursor_dirty_ff <= cursor_dirty_in;
            buffer_ready_ff <= buffer_ready_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= read_data_in;
         int_pulse_ff <= int_pulse_in;
         update_ff    <= update_in;
         clear_ff     <= clear_in;
      end
   end

   // state only moves on accept, so it matches the pending response
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.read_data       = read_data_ff;
   assign rsp_chan.interrupt_pulse = int_pulse_ff;
   assign rsp_chan.screen_update   = update_ff;
   assign rsp_chan.clear_screen    = clear_ff;
   assign rsp_chan.columns         = col_count_ff;
   assign rsp_chan.rows_out        = row_count_ff;
   assign rsp_chan.underline_line  = underline_ff;
   assign rsp_chan.cursor_format   = cursor_style_ff;
   assign rsp_chan.cursor_col      = cursor_x_ff;
   assign rsp_chan.cursor_row      = cursor_y_ff;

endmodule
